FILE: src/pts_pkg.sv
// Shared types and codes for the periodic task scheduler.
// No dependencies; imported by every module of the block.
package pts_pkg;

  typedef enum logic [2:0] {
    ACT_LOAD     = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_TRIGGER  = 3'd2,
    ACT_ITERATE  = 3'd3,
    ACT_COMPLETE = 3'd4,
    ACT_SETPRI   = 3'd5,
    ACT_SETPER   = 3'd6,
    ACT_RESTART  = 3'd7
  } action_t;

  localparam logic [2:0] KIND_ONCE   = 3'd0;
  localparam logic [2:0] KIND_STEADY = 3'd1;
  localparam logic [2:0] KIND_FREE   = 3'd2;
  localparam logic [2:0] KIND_EXT    = 3'd3;
  localparam logic [2:0] KIND_IDLE   = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_GRANT = 2'd1;
  localparam logic [1:0] ST_SLEEP = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] CFG_LOCKSTEP  = 2'd0;
  localparam logic [1:0] CFG_MAX_SLEEP = 2'd1;
  localparam logic [1:0] CFG_MIN_SLEEP = 2'd2;

  localparam logic [31:0] MAX_SLEEP_RESET = 32'd100000;
  localparam logic [31:0] MIN_SLEEP_RESET = 32'd1000;
  localparam logic signed [31:0] PRIO_MAX = 32'sh7fffffff;

  typedef enum logic {
    MD_DIV = 1'b0,
    MD_MUL = 1'b1
  } md_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MIN, S_ARM, S_SCAN, S_SLEEP,
    S_AGE, S_GRANT, S_DIV, S_MUL, S_OUT
  } state_t;

endpackage

FILE: src/pts_muldiv.sv
// Bit-serial 64-by-32 divider and 64-by-32 multiplier (product mod 2^64).
// Depends on pts_pkg for the operation code.
module pts_muldiv import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  md_op_t      op,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0] x;
  logic [63:0] y;
  logic [32:0] rem;
  logic [31:0] bv;
  logic [6:0]  cnt;
  md_op_t      opr;
  logic [32:0] trial;

  assign trial  = {rem[31:0], x[63]};
  assign result = (opr == MD_DIV) ? x : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= (op == MD_DIV) ? 7'd64 : 7'd32;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opr <= op;
      x   <= a;
      y   <= 64'd0;
      rem <= 33'd0;
      bv  <= b;
    end else if (busy) begin
      if (opr == MD_DIV) begin
        if (trial >= {1'b0, bv}) begin
          rem <= trial - {1'b0, bv};
          x   <= {x[62:0], 1'b1};
        end else begin
          rem <= trial;
          x   <= {x[62:0], 1'b0};
        end
      end else begin
        if (bv[0]) begin
          y <= y + x;
        end
        x  <= {x[62:0], 1'b0};
        bv <= {1'b0, bv[31:1]};
      end
    end
  end

endmodule

FILE: src/periodic_task_scheduler_core.sv
// Periodic task scheduler: slot table, sequencer and result register.
// An iterate sweeps the table to arm, scan and, if a slot is due, age (after a
// minimum sweep in lockstep mode); a steady completion runs the divider, then the
// multiplier if the skip limit is reached. One word is in flight at a time; the
// next is taken in the cycle after the result is loaded, and a stalled result
// holds it. Synchronous reset empties the table.
module periodic_task_scheduler_core import pts_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  slot,
  input  logic [63:0] now_time,
  input  logic [2:0]  kind,
  input  logic [31:0] start_delay,
  input  logic [31:0] task_period,
  input  logic signed [31:0] task_priority,
  input  logic [31:0] max_skip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  granted_slot,
  output logic [31:0] sleep_time,
  output logic [63:0] last_time,
  output logic signed [31:0] last_priority,
  output logic [63:0] sched_time,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t state, state_next;

  logic        lockstep_mode;
  logic [31:0] max_sleep;
  logic [31:0] min_sleep;

  logic [SLOTS-1:0] slot_valid, slot_active, slot_armed, slot_idle;
  logic [SLOTS-1:0] cand1, cand2, cand;
  logic [2:0]  slot_kind     [SLOTS];
  logic [63:0] due_time      [SLOTS];
  logic signed [31:0] base_priority [SLOTS];
  logic signed [31:0] aged_priority [SLOTS];
  logic [31:0] arm_delay     [SLOTS];
  logic [31:0] repeat_period [SLOTS];
  logic [31:0] skip_limit    [SLOTS];

  logic [63:0] current_time, granted_time;
  logic signed [31:0] granted_priority;
  logic        lock_eff;

  action_t     act;
  logic [3:0]  slot_r;
  logic [63:0] now_r;
  logic [2:0]  kind_r;
  logic [31:0] delay_r, period_r, mskip_r;
  logic signed [31:0] prio_r;

  logic [IW-1:0] idx, best, sidx, cidx;
  logic          have_best;
  logic signed [31:0] best_prio;
  logic [63:0]   minv;
  logic [1:0]    res_status;
  logic [3:0]    res_slot;
  logic [31:0]   res_sleep;

  logic [7:0]  slot8, best8;
  logic        inrange, ok, last;
  logic [2:0]  c_kind;
  logic [63:0] c_due, cand_d, min_new, end_time, sleep_d;
  logic        counts, c1, c2, found1, found2, better;
  logic signed [31:0] a_inc;
  logic        md_start, md_busy, md_done, skip_hit, steady_go;
  md_op_t      md_op;
  logic [63:0] md_a, md_res;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign slot8   = {4'd0, slot_r};
  assign best8   = 8'(best);
  assign sidx    = slot8[IW-1:0];
  assign inrange = {1'b0, slot8} < 9'(SLOTS);
  assign ok      = inrange && slot_valid[sidx];
  assign last    = (idx == IW'(SLOTS - 1));

  always_comb begin
    unique case (state)
      S_MIN, S_ARM, S_SCAN, S_AGE: cidx = idx;
      S_GRANT:                     cidx = best;
      default:                     cidx = sidx;
    endcase
  end

  assign c_kind   = slot_kind[cidx];
  assign c_due    = due_time[cidx];
  assign counts   = slot_valid[cidx] && (c_kind != KIND_IDLE) &&
                    !((c_kind == KIND_EXT) && !slot_active[cidx]);
  assign cand_d   = (counts && slot_armed[cidx]) ? c_due : '1;
  assign min_new  = (cand_d < minv) ? cand_d : minv;
  assign c1       = counts && (c_due <= current_time);
  assign c2       = slot_valid[cidx] && (c_kind == KIND_IDLE) &&
                    (c_due <= current_time) && slot_active[cidx];
  assign found1   = (|cand1) || c1;
  assign found2   = (|cand2) || c2;
  assign end_time = lock_eff ? current_time : now_r;
  assign a_inc    = (aged_priority[cidx] == PRIO_MAX) ? aged_priority[cidx]
                                                      : aged_priority[cidx] + 32'sd1;
  assign better   = !have_best || (a_inc > best_prio);
  assign sleep_d  = (minv > {32'd0, max_sleep}) ? {32'd0, max_sleep} : minv;
  assign skip_hit = md_res >= {32'd0, skip_limit[cidx]};
  assign steady_go = (act == ACT_COMPLETE) && ok && (c_kind == KIND_STEADY) &&
                     (repeat_period[cidx] != 32'd0);

  assign md_start = ((state == S_EXEC) && steady_go) ||
                    ((state == S_DIV) && md_done && skip_hit);
  assign md_op    = (state == S_EXEC) ? MD_DIV : MD_MUL;
  assign md_a     = (state == S_EXEC) ? (end_time - c_due) : md_res;

  pts_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .op     (md_op),
    .a      (md_a),
    .b      (repeat_period[cidx]),
    .busy   (md_busy),
    .done   (md_done),
    .result (md_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        unique case (act)
          ACT_ITERATE: begin
            if (!(|slot_valid)) state_next = S_OUT;
            else if (lockstep_mode) state_next = S_MIN;
            else state_next = S_ARM;
          end
          ACT_COMPLETE: state_next = steady_go ? S_DIV : S_OUT;
          ACT_RESTART:  state_next = S_ARM;
          default:      state_next = S_OUT;
        endcase
      end
      S_MIN:   if (last) state_next = S_ARM;
      S_ARM:   if (last) state_next = (act == ACT_RESTART) ? S_OUT : S_SCAN;
      S_SCAN:  if (last) state_next = (found1 || found2) ? S_AGE : S_SLEEP;
      S_SLEEP: state_next = S_OUT;
      S_AGE:   if (last) state_next = S_GRANT;
      S_GRANT: state_next = S_OUT;
      S_DIV:   if (md_done) state_next = skip_hit ? S_MUL : S_OUT;
      S_MUL:   if (md_done) state_next = S_OUT;
      S_OUT:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockstep_mode <= 1'b0;
      max_sleep     <= MAX_SLEEP_RESET;
      min_sleep     <= MIN_SLEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOCKSTEP:  lockstep_mode <= cfg_data[0];
        CFG_MAX_SLEEP: max_sleep <= cfg_data;
        CFG_MIN_SLEEP: min_sleep <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      status        <= res_status;
      granted_slot  <= res_slot;
      sleep_time    <= res_sleep;
      last_time     <= granted_time;
      last_priority <= granted_priority;
      sched_time    <= current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid       <= '0;
      slot_active      <= '0;
      slot_armed       <= '0;
      slot_idle        <= '0;
      current_time     <= 64'd0;
      granted_time     <= 64'd0;
      granted_priority <= 32'sd0;
      lock_eff         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act        <= action_t'(action);
            slot_r     <= slot;
            now_r      <= now_time;
            kind_r     <= kind;
            delay_r    <= start_delay;
            period_r   <= task_period;
            prio_r     <= task_priority;
            mskip_r    <= max_skip;
            res_status <= ST_DONE;
            res_slot   <= 4'd0;
            res_sleep  <= 32'd0;
          end
        end
        S_EXEC: begin
          idx       <= '0;
          minv      <= '1;
          cand1     <= '0;
          cand2     <= '0;
          have_best <= 1'b0;
          unique case (act)
            ACT_LOAD: begin
              if (inrange && kind_r <= KIND_IDLE) begin
                slot_valid[sidx]    <= 1'b1;
                slot_active[sidx]   <= 1'b0;
                slot_armed[sidx]    <= 1'b0;
                slot_idle[sidx]     <= (kind_r == KIND_IDLE);
                slot_kind[sidx]     <= kind_r;
                due_time[sidx]      <= 64'd0;
                arm_delay[sidx]     <= delay_r;
                repeat_period[sidx] <= period_r;
                base_priority[sidx] <= prio_r;
                aged_priority[sidx] <= 32'sd0;
                skip_limit[sidx]    <= mskip_r;
              end
            end
            ACT_REMOVE: begin
              if (ok) begin
                slot_valid[sidx]  <= 1'b0;
                slot_active[sidx] <= 1'b0;
                slot_armed[sidx]  <= 1'b0;
              end
            end
            ACT_TRIGGER: begin
              if (ok && c_kind == KIND_EXT && slot_armed[sidx] && !slot_active[sidx]) begin
                if (end_time > c_due) due_time[sidx] <= end_time;
                slot_active[sidx] <= 1'b1;
              end
            end
            ACT_ITERATE: begin
              if (!(|slot_valid)) begin
                res_status <= ST_EMPTY;
              end else begin
                lock_eff <= lockstep_mode;
                if (!lockstep_mode) current_time <= now_r;
              end
            end
            ACT_COMPLETE: begin
              if (ok) begin
                if (c_kind == KIND_ONCE) begin
                  slot_valid[sidx]  <= 1'b0;
                  slot_active[sidx] <= 1'b0;
                  slot_armed[sidx]  <= 1'b0;
                end else if (c_kind == KIND_FREE) begin
                  due_time[sidx] <= end_time + {32'd0, repeat_period[sidx]};
                end
              end
            end
            ACT_SETPRI: if (ok) aged_priority[sidx] <= prio_r;
            ACT_SETPER: if (ok) repeat_period[sidx] <= period_r;
            default: begin
              current_time     <= 64'd0;
              granted_time     <= 64'd0;
              granted_priority <= 32'sd0;
              slot_armed       <= '0;
              slot_active      <= slot_valid & slot_idle;
            end
          endcase
        end
        S_MIN: begin
          minv <= min_new;
          idx  <= last ? '0 : idx + IW'(1);
          if (last) current_time <= min_new;
        end
        S_ARM: begin
          if (slot_valid[idx] && !slot_armed[idx]) begin
            due_time[idx]      <= current_time + {32'd0, arm_delay[idx]};
            aged_priority[idx] <= base_priority[idx];
            slot_armed[idx]    <= 1'b1;
          end
          idx  <= last ? '0 : idx + IW'(1);
          minv <= '1;
        end
        S_SCAN: begin
          cand1[idx] <= c1;
          cand2[idx] <= c2;
          idx  <= last ? '0 : idx + IW'(1);
          if (!last) begin
            minv <= min_new;
          end else begin
            if (found1) begin
              cand        <= cand1 | ((SLOTS)'(c1) << idx);
              slot_active <= slot_active | (slot_valid & slot_idle);
            end else if (found2) begin
              cand <= cand2 | ((SLOTS)'(c2) << idx);
            end else begin
              slot_active <= slot_active | (slot_valid & slot_idle);
              minv        <= min_new - current_time;
            end
          end
        end
        S_SLEEP: begin
          res_status <= ST_SLEEP;
          res_sleep  <= (sleep_d < {32'd0, min_sleep}) ? min_sleep : sleep_d[31:0];
        end
        S_AGE: begin
          if (cand[idx]) begin
            aged_priority[idx] <= a_inc;
            if (better) begin
              have_best <= 1'b1;
              best      <= idx;
              best_prio <= a_inc;
            end
          end
          idx <= last ? '0 : idx + IW'(1);
        end
        S_GRANT: begin
          granted_time        <= c_due;
          granted_priority    <= best_prio;
          aged_priority[best] <= base_priority[best];
          slot_active[best]   <= 1'b0;
          res_status          <= ST_GRANT;
          res_slot            <= best8[3:0];
        end
        S_DIV: begin
          if (md_done && !skip_hit) begin
            due_time[sidx] <= c_due + {32'd0, repeat_period[sidx]};
          end
        end
        S_MUL: begin
          if (md_done) due_time[sidx] <= c_due + md_res;
        end
        default: ;
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted word did not start execution");

  a_grant_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_GRANT) |=> (state == S_OUT && res_status == ST_GRANT))
    else $error("grant did not reach the result stage");

  a_md_busy: assert property (@(posedge clk) disable iff (rst)
    md_busy |-> (state == S_DIV || state == S_MUL))
    else $error("arithmetic unit busy outside completion");

  a_best_cand: assert property (@(posedge clk) disable iff (rst)
    (state == S_GRANT) |-> (have_best && cand[best]))
    else $error("granted slot was not a candidate");

endmodule
